// ===== design/can_telemetry_frame_decoder_defines.svh =====
`ifndef CAN_TELEMETRY_FRAME_DECODER_DEFINES_SVH
`define CAN_TELEMETRY_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low.
`define CTFD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while aresetn is low.
`define CTFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ctfd_pkg.sv =====
`default_nettype none

package ctfd_pkg;

    // Stream widths
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 64;
    localparam int PADDR_W  = 2;

    // Frame identifiers
    localparam logic [28:0] ID_INVERTER = 29'd1;
    localparam logic [28:0] ID_CHARGER1 = 29'd519;
    localparam logic [28:0] ID_CHARGER2 = 29'd521;
    localparam logic [28:0] ID_CHARGER3 = 29'd523;

    localparam logic [31:0] TACH_SCALE_RESET = 32'd29580000;

    // Result kinds
    localparam logic KIND_INVERTER = 1'b0;
    localparam logic KIND_CHARGER  = 1'b1;

    // Charger current / 15 as multiply by 2185 and shift by 15 (exact for 9 bits)
    localparam int          AMPS_DIVISOR = 15;
    localparam logic [11:0] AMPS_RECIP   = 12'd2185;
    localparam int          AMPS_SHIFT   = 15;

    // Volts sum / 3 as multiply by 683 and shift by 11 (exact below 1024)
    localparam logic [9:0] THIRD_RECIP = 10'd683;
    localparam int         THIRD_SHIFT = 11;

    // Temperature window
    localparam int TEMP_WINDOW    = 16;
    localparam int TEMP_DIVISOR   = 10;
    localparam int WIN_W          = $clog2(TEMP_WINDOW);
    localparam int SUM_W          = 16 + WIN_W;
    localparam int TEMP_DIV_TOTAL = TEMP_DIVISOR * TEMP_WINDOW;
    localparam int TEMP_LOG       = $clog2(TEMP_DIV_TOTAL);
    localparam int TEMP_SHIFT     = SUM_W + TEMP_LOG;
    localparam longint unsigned TEMP_RECIP =
        ((64'd1 << TEMP_SHIFT) + TEMP_DIV_TOTAL - 1) / TEMP_DIV_TOTAL;
    localparam int RECIP_W        = SUM_W + 2;
    localparam int PROD_W         = SUM_W + RECIP_W;

    // Tach divider
    localparam int DIV_W = 32;
    localparam int DVS_W = 16;
    localparam int CNT_W = $clog2(DIV_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INV_AVG,
        ST_INV_MUL,
        ST_INV_WAIT,
        ST_CHG_SUM,
        ST_CHG_DIV,
        ST_DONE
    } ctfd_state_t;

    typedef struct packed {
        logic accept;
        logic avg_step;
        logic mul_step;
        logic sum_step;
        logic vdiv_step;
        logic out_load;
    } ctfd_cmd_t;

    typedef struct packed {
        logic id_inv;
        logic id_chg;
        logic div_busy;
        logic out_free;
    } ctfd_stat_t;

endpackage

`default_nettype wire

// ===== design/ctfd_div.sv =====
`default_nettype none
`include "can_telemetry_frame_decoder_defines.svh"

module ctfd_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [ctfd_pkg::DIV_W-1:0]   dividend,
    input  wire logic [ctfd_pkg::DVS_W-1:0]   divisor,
    output logic                              busy,
    output logic [ctfd_pkg::DIV_W-1:0]        quotient
);

    logic [ctfd_pkg::DVS_W:0]   rem_reg, rem_next;
    logic [ctfd_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [ctfd_pkg::DVS_W-1:0] dvs_reg, dvs_next;
    logic [ctfd_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic [ctfd_pkg::DVS_W:0]   rem_shift;
    logic [ctfd_pkg::DVS_W+1:0] trial;

    // Restoring division, one quotient bit per cycle
    always_comb begin
        rem_shift = {rem_reg[ctfd_pkg::DVS_W-1:0], quo_reg[ctfd_pkg::DIV_W-1]};
        trial     = {1'b0, rem_shift} - {2'b00, dvs_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = ctfd_pkg::CNT_W'(ctfd_pkg::DIV_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial[ctfd_pkg::DVS_W+1]) begin
                rem_next = rem_shift;
                quo_next = {quo_reg[ctfd_pkg::DIV_W-2:0], 1'b0};
            end else begin
                rem_next = trial[ctfd_pkg::DVS_W:0];
                quo_next = {quo_reg[ctfd_pkg::DIV_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

    `CTFD_ASSERT_NEXT(a_div_start_busy, start, busy_reg, "divider did not start")
    `CTFD_ASSERT_NEXT(a_div_finish, busy_reg && cnt_reg == '0 && !start, !busy_reg,
        "divider ran past its last bit")

endmodule

`default_nettype wire

// ===== design/ctfd_datapath.sv =====
`default_nettype none
`include "can_telemetry_frame_decoder_defines.svh"

module ctfd_datapath (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire ctfd_pkg::ctfd_cmd_t               cmd,
    output ctfd_pkg::ctfd_stat_t                   stat,
    input  wire logic [31:0]                       tach_scale,
    input  wire logic [ctfd_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [ctfd_pkg::M_DATA_W-1:0]          m_tdata,
    output logic                                   m_tuser
);

    logic [28:0] frame_id;
    logic [7:0]  byte1, byte2, byte3, byte4, byte5, byte6;
    logic        id_inv, id_chg;
    logic [1:0]  chg_idx;
    logic [15:0] rpm;
    logic [15:0] sample;
    logic [8:0]  amps_field;
    logic [20:0] amps_prod;
    logic        div_start, div_busy;
    logic [ctfd_pkg::DIV_W-1:0] quotient;

    logic [15:0]                win_reg [ctfd_pkg::TEMP_WINDOW];
    logic [ctfd_pkg::WIN_W-1:0] slot_reg;
    logic [ctfd_pkg::SUM_W-1:0] temp_sum_reg;
    logic [ctfd_pkg::SUM_W-1:0] temp_sum_next;
    logic [ctfd_pkg::SUM_W-1:0] mag_reg;
    logic                       neg_reg;
    logic [ctfd_pkg::PROD_W-1:0] prod_reg;
    logic [12:0]                t_mag, temp_out;

    logic [7:0]  volts_reg [3];
    logic [5:0]  amps_reg [3];
    logic [9:0]  vsum_reg, vsum_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [6:0]  isum_reg, isum_next;
    logic [19:0] third_prod;
    logic [7:0]  vavg_reg, vavg_next;

    logic        kind_reg;
    logic        rpm_zero_reg;
    logic [30:0] tach_out;

    logic                           m_tvalid_reg, m_tvalid_next;
    logic [ctfd_pkg::M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                           m_tuser_reg, m_tuser_next;

    // Field split
    assign frame_id   = s_tdata[28:0];
    assign byte1      = s_tdata[36:29];
    assign byte2      = s_tdata[44:37];
    assign byte3      = s_tdata[52:45];
    assign byte4      = s_tdata[60:53];
    assign byte5      = s_tdata[68:61];
    assign byte6      = s_tdata[76:69];

    assign id_inv     = (frame_id == ctfd_pkg::ID_INVERTER);
    assign id_chg     = (frame_id == ctfd_pkg::ID_CHARGER1) ||
                        (frame_id == ctfd_pkg::ID_CHARGER2) ||
                        (frame_id == ctfd_pkg::ID_CHARGER3);
    assign chg_idx    = (frame_id == ctfd_pkg::ID_CHARGER1) ? 2'd0 :
                        (frame_id == ctfd_pkg::ID_CHARGER2) ? 2'd1 : 2'd2;
    assign rpm        = {byte5, byte4};
    assign sample     = {byte3, byte2};
    assign amps_field = {byte6[1:0], byte5[7:1]};
    assign amps_prod  = 21'(amps_field) * 21'(ctfd_pkg::AMPS_RECIP);

    assign div_start  = cmd.accept && id_inv && (rpm != '0);

    ctfd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (tach_scale),
        .divisor  (rpm),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // Window update: drop the oldest sample, add the new one
    assign temp_sum_next = temp_sum_reg
                         - {{ctfd_pkg::WIN_W{win_reg[slot_reg][15]}}, win_reg[slot_reg]}
                         + {{ctfd_pkg::WIN_W{sample[15]}}, sample};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ctfd_pkg::TEMP_WINDOW; i++) begin
                win_reg[i] <= '0;
            end
            slot_reg     <= '0;
            temp_sum_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                volts_reg[i] <= '0;
                amps_reg[i]  <= '0;
            end
        end else if (cmd.accept && id_inv) begin
            win_reg[slot_reg] <= sample;
            temp_sum_reg      <= temp_sum_next;
            if (slot_reg == ctfd_pkg::WIN_W'(ctfd_pkg::TEMP_WINDOW - 1)) begin
                slot_reg <= '0;
            end else begin
                slot_reg <= slot_reg + 1'b1;
            end
        end else if (cmd.accept && id_chg) begin
            volts_reg[chg_idx] <= byte1;
            amps_reg[chg_idx]  <= amps_prod[ctfd_pkg::AMPS_SHIFT +: 6];
        end
    end

    // Charger sums and mean
    always_comb begin
        vsum_next = '0;
        cnt_next  = '0;
        isum_next = '0;
        for (int i = 0; i < 3; i++) begin
            if (volts_reg[i] != '0) begin
                vsum_next = vsum_next + 10'(volts_reg[i]);
                cnt_next  = cnt_next + 1'b1;
            end
            isum_next = isum_next + 7'(amps_reg[i]);
        end
    end

    assign third_prod = 20'(vsum_reg) * 20'(ctfd_pkg::THIRD_RECIP);

    always_comb begin
        case (cnt_reg)
            2'd0:    vavg_next = '0;
            2'd1:    vavg_next = vsum_reg[7:0];
            2'd2:    vavg_next = vsum_reg[8:1];
            default: vavg_next = third_prod[ctfd_pkg::THIRD_SHIFT +: 8];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg     <= id_chg ? ctfd_pkg::KIND_CHARGER : ctfd_pkg::KIND_INVERTER;
            rpm_zero_reg <= (rpm == '0);
        end
        if (cmd.avg_step) begin
            neg_reg <= temp_sum_reg[ctfd_pkg::SUM_W-1];
            mag_reg <= temp_sum_reg[ctfd_pkg::SUM_W-1] ? (~temp_sum_reg + 1'b1) : temp_sum_reg;
        end
        if (cmd.mul_step) begin
            prod_reg <= ctfd_pkg::PROD_W'(mag_reg) *
                        ctfd_pkg::PROD_W'(ctfd_pkg::TEMP_RECIP);
        end
        if (cmd.sum_step) begin
            vsum_reg <= vsum_next;
            cnt_reg  <= cnt_next;
            isum_reg <= isum_next;
        end
        if (cmd.vdiv_step) begin
            vavg_reg <= vavg_next;
        end
    end

    assign t_mag    = prod_reg[ctfd_pkg::TEMP_SHIFT +: 13];
    assign temp_out = neg_reg ? (~t_mag + 1'b1) : t_mag;
    assign tach_out = rpm_zero_reg ? '0 : quotient[ctfd_pkg::DIV_W-1:1];

    // Output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = kind_reg;
            if (kind_reg == ctfd_pkg::KIND_CHARGER) begin
                m_tdata_next = {5'd0, isum_reg, vavg_reg, 13'd0, 31'd0};
            end else begin
                m_tdata_next = {5'd0, 7'd0, 8'd0, temp_out, tach_out};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;
    assign m_tuser       = m_tuser_reg;

    assign stat.id_inv   = id_inv;
    assign stat.id_chg   = id_chg;
    assign stat.div_busy = div_busy;
    assign stat.out_free = !m_tvalid_reg || m_tready;

    `CTFD_ASSERT_SAME(a_dp_accept_div_idle, cmd.accept, !div_busy,
        "frame accepted while tach divider busy")
    `CTFD_ASSERT_SAME(a_dp_no_overwrite, cmd.out_load, !m_tvalid_reg || m_tready,
        "result overwritten before it was taken")

endmodule

`default_nettype wire

// ===== design/ctfd_ctrl.sv =====
`default_nettype none

module ctfd_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire ctfd_pkg::ctfd_stat_t  stat,
    output ctfd_pkg::ctfd_cmd_t        cmd
);

    ctfd_pkg::ctfd_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ctfd_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (stat.id_inv) begin
                        state_next = ctfd_pkg::ST_INV_AVG;
                    end else if (stat.id_chg) begin
                        state_next = ctfd_pkg::ST_CHG_SUM;
                    end
                end
            end
            ctfd_pkg::ST_INV_AVG:  state_next = ctfd_pkg::ST_INV_MUL;
            ctfd_pkg::ST_INV_MUL:  state_next = ctfd_pkg::ST_INV_WAIT;
            ctfd_pkg::ST_INV_WAIT: begin
                if (!stat.div_busy) begin
                    state_next = ctfd_pkg::ST_DONE;
                end
            end
            ctfd_pkg::ST_CHG_SUM:  state_next = ctfd_pkg::ST_CHG_DIV;
            ctfd_pkg::ST_CHG_DIV:  state_next = ctfd_pkg::ST_DONE;
            ctfd_pkg::ST_DONE: begin
                if (stat.out_free) begin
                    state_next = ctfd_pkg::ST_IDLE;
                end
            end
            default:               state_next = ctfd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready      = (state_reg == ctfd_pkg::ST_IDLE);
        cmd.accept    = s_tvalid && (state_reg == ctfd_pkg::ST_IDLE);
        cmd.avg_step  = (state_reg == ctfd_pkg::ST_INV_AVG);
        cmd.mul_step  = (state_reg == ctfd_pkg::ST_INV_MUL);
        cmd.sum_step  = (state_reg == ctfd_pkg::ST_CHG_SUM);
        cmd.vdiv_step = (state_reg == ctfd_pkg::ST_CHG_DIV);
        cmd.out_load  = (state_reg == ctfd_pkg::ST_DONE) && stat.out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ctfd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/can_telemetry_frame_decoder.sv =====
// CAN telemetry frame decoder.
// Input stream (s_*): one beat per received CAN frame. Output stream (m_*): one
// beat per inverter frame (identifier 1) or charger frame (519, 521, 523); any
// other identifier is consumed and gives no beat.
// Inverter beat: tach half period = (tach_scale / rpm) / 2, or 0 when rpm is 0,
// plus a 16-sample moving average of the heatsink temperature divided by ten.
// Charger beat: mean volts over chargers with nonzero volts and summed current.
// Inverter frame: window average and multiply steps, then a wait for the bit-serial
// tach divider (one quotient bit per clock while it runs), which is not started when
// rpm is 0; charger frame: sum and divide steps. One frame is in work at a time and
// s_tready rises together with m_tvalid.
// A finished result sits in the output register; the next frame is accepted
// while it waits. If the receiver stalls with a result still held, the next
// finished result holds inside the block and s_tready stays low until m_tready.
// Reset (aresetn low, synchronous) clears the window, charger values and tach_scale
// to 29580000. tach_scale is written over the APB port at offset 0; the user must
// write it only while idle, and the block itself does not enforce this.
`default_nettype none

module can_telemetry_frame_decoder (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // APB configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [ctfd_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,
    // Input frames
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // frame_id[28:0], byte1[36:29], byte2[44:37], byte3[52:45],
    // byte4[60:53], byte5[68:61], byte6[76:69], zero fill [79:77]
    input  wire logic [ctfd_pkg::S_DATA_W-1:0]     s_tdata,
    // Results
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // tach_half_period[30:0], heatsink_temp[43:31], charger_volts_avg[51:44],
    // charger_current_sum[58:52], zero fill [63:59]
    output logic [ctfd_pkg::M_DATA_W-1:0]          m_tdata,
    // result_kind[0]
    output logic                                   m_tuser
);

    logic [31:0]          tach_scale_reg, tach_scale_next;
    ctfd_pkg::ctfd_cmd_t  cmd;
    ctfd_pkg::ctfd_stat_t stat;

    // Only one register, so every address in range maps to tach_scale
    always_comb begin
        tach_scale_next = tach_scale_reg;
        if (psel && penable && pwrite && pready) begin
            tach_scale_next = pwdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tach_scale_reg <= ctfd_pkg::TACH_SCALE_RESET;
        end else begin
            tach_scale_reg <= tach_scale_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == '0) ? tach_scale_reg : tach_scale_reg;

    // Sequence each frame through the datapath
    ctfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Window, charger store, divider and output register
    ctfd_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .tach_scale (tach_scale_reg),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire
